[rtl/aes_pkg.sv]
package aes_pkg;

    localparam int unsigned KeyWords  = 60;
    localparam int unsigned KeyAddrW  = 6;
    localparam int unsigned NumRounds = 14;

    typedef enum logic [2:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_IV_HI  = 3'd4,
        REG_IV_LO  = 3'd5
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND,
        ST_OUTPUT
    } t_state;

    // Request from the controller to the round datapath.
    typedef struct packed {
        logic       load;
        logic       step;
        logic       last;
    } t_rnd_ctl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

[rtl/aes_stream_if.sv]
interface aes_stream_if #(
    parameter int unsigned Width = 134
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/aes_ram.sv]
module aes_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 64,
    parameter int unsigned AddrW = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/aes_round.sv]
module aes_round
    import aes_pkg::*;
(
    input  logic          i_clk,
    input  t_rnd_ctl      i_ctl,
    input  logic [127:0]  i_block,
    input  logic [127:0]  i_key,
    output logic [127:0]  o_state
);
    logic [127:0] r_state;
    logic [127:0] n_state;
    logic [7:0]   sb [16];
    logic [7:0]   mc [16];

    // Byte n of the block sits at bits [127-8n -: 8].
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[4*c+r] = SBOX[r_state[127 - 8*(4*((c+r)%4)+r) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            mc[4*c]   = xtime(sb[4*c]   ^ sb[4*c+1]) ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
            mc[4*c+1] = xtime(sb[4*c+1] ^ sb[4*c+2]) ^ sb[4*c+2] ^ sb[4*c+3] ^ sb[4*c];
            mc[4*c+2] = xtime(sb[4*c+2] ^ sb[4*c+3]) ^ sb[4*c+3] ^ sb[4*c]   ^ sb[4*c+1];
            mc[4*c+3] = xtime(sb[4*c+3] ^ sb[4*c])   ^ sb[4*c]   ^ sb[4*c+1] ^ sb[4*c+2];
        end
        n_state = r_state;
        if (i_ctl.load) begin
            n_state = i_block ^ i_key;
        end else if (i_ctl.step) begin
            for (int i = 0; i < 16; i++) begin
                n_state[127 - 8*i -: 8] = (i_ctl.last ? sb[i] : mc[i]) ^ i_key[127 - 8*i -: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
    end

    // The output is the state as it stands after this cycle's operation, so the
    // final round's result is available in the cycle that performs it.
    assign o_state = n_state;
endmodule

[rtl/aes256_ctr_cipher.sv]
// An item without reload runs the 15 key additions from the stored round keys:
// the key memory delivers one round-key word per cycle, so each key addition waits
// for its four words, and the memory read is registered. With reload_counter set,
// key expansion first writes the 60 round-key words one per cycle.
// A new item is accepted only once the previous result has been taken.
// Reset (synchronous, active low) clears the configuration and control registers and
// the counter; the round-key memory holds no value until the first reload expands it.
module aes256_ctr_cipher
    import aes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    aes_stream_if.sink   in_if,
    aes_stream_if.source out_if
);
    // Input payload: {data_high, data_low, byte_count, reload_counter}.
    // Output payload: {result_high, result_low, result_count, 1'b0}.

    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_iv_hi, r_iv_lo;
    logic [127:0] r_ctr;
    logic [127:0] r_data;
    logic [4:0]   r_count;
    t_state       r_state, n_state;

    // Key expansion: word index and a sliding window of the last 8 words,
    // so expansion needs only writes; rounds read the memory one word a cycle.
    logic [5:0]   r_kidx;
    logic [31:0]  r_win [8];
    logic [3:0]   r_round;
    logic [1:0]   r_col;
    logic         r_rvalid;
    logic [95:0]  r_kacc;
    logic [127:0] r_out;
    logic         r_out_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0; r_key1 <= '0; r_key2 <= '0; r_key3 <= '0;
            r_iv_hi <= '0; r_iv_lo <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY0:  r_key0  <= i_cfg_data;
                REG_KEY1:  r_key1  <= i_cfg_data;
                REG_KEY2:  r_key2  <= i_cfg_data;
                REG_KEY3:  r_key3  <= i_cfg_data;
                REG_IV_HI: r_iv_hi <= i_cfg_data;
                REG_IV_LO: r_iv_lo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next key word during expansion.
    logic [31:0] key_init;
    logic [31:0] key_next;
    logic [31:0] key_wdata;
    logic [31:0] rot_t;
    logic [7:0]  rcon;
    always_comb begin
        case (r_kidx[2:0])
            3'd0: key_init = r_key0[63:32];
            3'd1: key_init = r_key0[31:0];
            3'd2: key_init = r_key1[63:32];
            3'd3: key_init = r_key1[31:0];
            3'd4: key_init = r_key2[63:32];
            3'd5: key_init = r_key2[31:0];
            3'd6: key_init = r_key3[63:32];
            default: key_init = r_key3[31:0];
        endcase
        rcon = 8'h01 << (r_kidx[5:3] - 3'd1);
        rot_t = r_win[7];
        if (r_kidx[2:0] == 3'd0) begin
            rot_t = sub_word({r_win[7][23:0], r_win[7][31:24]}) ^ {rcon, 24'h0};
        end else if (r_kidx[2:0] == 3'd4) begin
            rot_t = sub_word(r_win[7]);
        end
        key_next = r_win[0] ^ rot_t;
        key_wdata = (r_kidx < 6'd8) ? key_init : key_next;
    end

    // Key memory read address: word 4*round + column.
    logic [5:0]  key_raddr;
    logic [31:0] key_rdata;
    logic        key_we;
    assign key_raddr = {r_round, r_col};
    assign key_we = (r_state == ST_EXPAND);

    aes_ram #(.Width(32), .Depth(KeyWords), .AddrW(KeyAddrW)) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_kidx),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    t_rnd_ctl     rnd_ctl;
    logic [127:0] rnd_state;
    logic [127:0] round_key;
    logic         key_full;
    assign round_key = {r_kacc, key_rdata};
    assign key_full  = r_rvalid && (r_col == 2'd0);

    // The round unit's output is its state after the current operation; in the
    // cycle of the last round it is the keystream.
    aes_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (rnd_ctl),
        .i_block (r_ctr),
        .i_key   (round_key),
        .o_state (rnd_state)
    );

    // The round number whose key just arrived is one behind the read pointer
    // when the column counter has wrapped.
    logic [3:0] key_round;
    assign key_round = r_round - 4'd1;

    always_comb begin
        rnd_ctl.load  = (r_state == ST_ROUND) && key_full && (key_round == 4'd0);
        rnd_ctl.step  = (r_state == ST_ROUND) && key_full && (key_round != 4'd0);
        rnd_ctl.last  = (key_round == 4'(NumRounds));
    end

    logic in_fire, out_fire, done;
    assign in_fire  = in_if.valid && in_if.ready;
    assign out_fire = out_if.valid && out_if.ready;
    assign done     = rnd_ctl.step && rnd_ctl.last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_fire) n_state = in_if.payload[0] ? ST_EXPAND : ST_ROUND;
            ST_EXPAND: if (r_kidx == 6'(KeyWords - 1)) n_state = ST_ROUND;
            ST_ROUND:  if (done) n_state = ST_OUTPUT;
            ST_OUTPUT: if (!r_out_valid) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_if.ready = (r_state == ST_IDLE);
    end

    // Masked result: bytes past the count are zero, count saturates at 16.
    logic [4:0]   sat_count;
    logic [127:0] masked;
    always_comb begin
        sat_count = (r_count > 5'd16) ? 5'd16 : r_count;
        masked = '0;
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < sat_count) begin
                masked[127 - 8*i -: 8] = r_data[127 - 8*i -: 8];
            end
        end
    end

    function automatic logic [127:0] mask_bits(input logic [4:0] cnt);
        logic [127:0] m;
        m = '0;
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < cnt) m[127 - 8*i -: 8] = 8'hff;
        end
        return m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ctr <= '0;
            r_kidx <= '0;
            r_round <= '0;
            r_col <= '0;
            r_rvalid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_data <= in_if.payload[133:6];
                r_count <= in_if.payload[5:1];
                r_kidx <= '0;
                r_round <= '0;
                r_col <= '0;
                r_rvalid <= 1'b0;
                if (in_if.payload[0]) begin
                    r_ctr <= {r_iv_hi, r_iv_lo};
                end
            end
            if (r_state == ST_EXPAND) begin
                r_kidx <= r_kidx + 6'd1;
                for (int i = 0; i < 7; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[7] <= key_wdata;
            end
            if (r_state == ST_ROUND) begin
                r_rvalid <= (r_round <= 4'(NumRounds));
                if (r_round <= 4'(NumRounds)) begin
                    {r_round, r_col} <= {r_round, r_col} + 6'd1;
                end
                r_kacc <= {r_kacc[63:0], key_rdata};
            end
            if (done) begin
                r_ctr <= r_ctr + 128'd1;
                r_out <= masked ^ (rnd_state & mask_bits(sat_count));
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign out_if.valid   = r_out_valid;
    assign out_if.payload = {r_out, sat_count, 1'b0};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_out_valid) else $error("result not raised after last round");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXPAND) |-> !in_if.ready) else $error("ready during expansion");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_ctr == $past(r_ctr) + 128'd1) else $error("counter did not advance");
endmodule
